// ===== rtl/dpfa_pkg.sv =====
// Package for the device placement fit allocator.
// Widths, operation/mode/register codes and the controller-datapath structs.
// No dependencies.
`default_nettype none

package dpfa_pkg;

	localparam int DEF_MAX_DEVICES = 8;
	localparam int DEF_MEM_BITS    = 48;

	localparam int OPC_W    = 2;
	localparam int MASK_W   = 8;
	localparam int REQ_W    = 48;
	localparam int OFFSET_W = 32;
	localparam int DEVOUT_W = 3;
	localparam int MODE_W   = 2;
	localparam int NDEV_W   = 4;
	localparam int SLOT_W   = 16;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// remainder unit: offset bits consumed per cycle
	localparam int MOD_DIGIT = 8;
	localparam int MOD_STEPS = OFFSET_W / MOD_DIGIT;

	localparam logic [OPC_W-1:0] OP_RESERVE = 2'd0;
	localparam logic [OPC_W-1:0] OP_FINISH  = 2'd1;
	localparam logic [OPC_W-1:0] OP_RETURN  = 2'd2;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
	localparam logic [MODE_W-1:0] FIT_RR    = 2'd3;

	localparam logic [1:0] REG_FIT_MODE    = 2'd0;
	localparam logic [1:0] REG_NUM_DEVICES = 2'd1;
	localparam logic [1:0] REG_MAX_TASKS   = 2'd2;

	localparam logic [NDEV_W-1:0] RST_NUM_DEVICES = 4'd8;
	localparam logic [SLOT_W-1:0] RST_MAX_TASKS   = 16'd16;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic scan_issue;
		logic tgt_read;
		logic commit;
		logic apply;
		logic reject;
	} dpfa_cmd_t;

	typedef struct packed {
		logic op_reserve;
		logic tgt_ok;
		logic n_zero;
		logic mod_last;
		logic scan_last;
	} dpfa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/device_placement_fit_allocator_core.sv =====
// Top level of the device placement fit allocator: registers, controller,
// datapath. Depends on dpfa_pkg, dpfa_regs, dpfa_ctrl, dpfa_dp, dpfa_ram.
//
// Usage: an operation is taken when start is high and busy is low; its single
// result appears on granted/chosen_device/remaining_bytes for exactly one
// cycle with done high, and the receiver cannot stall it. A reservation holds
// busy through decode, the offset remainder unit (eight offset bits per
// cycle), a scan that reads the devices in use one at a time from the
// per-device state RAM through its single read port, then the drain and
// commit states. Finish and return hold busy through decode and a
// read-modify-write state; rejected operations through decode only. The next
// operation can be taken in the cycle done is shown. Per-device state starts
// at zero after reset through valid bits, with no clearing pass.
`default_nettype none

module device_placement_fit_allocator_core #(
	parameter int MAX_DEVICES = dpfa_pkg::DEF_MAX_DEVICES,
	parameter int MEM_BITS    = dpfa_pkg::DEF_MEM_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [dpfa_pkg::PADDR_W-1:0]   paddr,
	input  wire  [dpfa_pkg::PDATA_W-1:0]   pwdata,
	output logic [dpfa_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  wire                            start,
	output logic                           busy,
	input  wire  [dpfa_pkg::OPC_W-1:0]     opcode,
	input  wire  [dpfa_pkg::MASK_W-1:0]    device_mask,
	input  wire  [dpfa_pkg::REQ_W-1:0]     request_bytes,
	input  wire  [dpfa_pkg::OFFSET_W-1:0]  start_offset,
	input  wire  [dpfa_pkg::DEVOUT_W-1:0]  target_device,
	output logic                           done,
	output logic                           granted,
	output logic [dpfa_pkg::DEVOUT_W-1:0]  chosen_device,
	output logic [dpfa_pkg::REQ_W-1:0]     remaining_bytes
);
	import dpfa_pkg::*;

	logic [MODE_W-1:0] fit_mode;
	logic [NDEV_W-1:0] num_devices;
	logic [SLOT_W-1:0] max_tasks;
	dpfa_cmd_t         cmd;
	dpfa_stat_t        stat;

	dpfa_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fit_mode   (fit_mode),
		.num_devices(num_devices),
		.max_tasks  (max_tasks)
	);

	dpfa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.stat  (stat)
	);

	dpfa_dp #(
		.MAX_DEVICES(MAX_DEVICES),
		.MEM_BITS   (MEM_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.fit_mode       (fit_mode),
		.num_devices    (num_devices),
		.max_tasks      (max_tasks),
		.opcode         (opcode),
		.device_mask    (device_mask),
		.request_bytes  (request_bytes),
		.start_offset   (start_offset),
		.target_device  (target_device),
		.done           (done),
		.granted        (granted),
		.chosen_device  (chosen_device),
		.remaining_bytes(remaining_bytes)
	);

endmodule

`default_nettype wire

// ===== rtl/dpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dpfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire                                  clk,
	input  wire                                  wr_en,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire  [WIDTH-1:0]                     wr_data,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/dpfa_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on dpfa_pkg.
`default_nettype none

module dpfa_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [dpfa_pkg::PADDR_W-1:0] paddr,
	input  wire  [dpfa_pkg::PDATA_W-1:0] pwdata,
	output logic [dpfa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [dpfa_pkg::MODE_W-1:0]  fit_mode,
	output logic [dpfa_pkg::NDEV_W-1:0]  num_devices,
	output logic [dpfa_pkg::SLOT_W-1:0]  max_tasks
);
	import dpfa_pkg::*;

	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode    <= FIT_FIRST;
			num_devices <= RST_NUM_DEVICES;
			max_tasks   <= RST_MAX_TASKS;
		end else if (wr) begin
			unique case (idx)
				REG_FIT_MODE:    fit_mode    <= pwdata[MODE_W-1:0];
				REG_NUM_DEVICES: num_devices <= pwdata[NDEV_W-1:0];
				REG_MAX_TASKS:   max_tasks   <= pwdata[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FIT_MODE:    prdata = PDATA_W'(fit_mode);
			REG_NUM_DEVICES: prdata = PDATA_W'(num_devices);
			REG_MAX_TASKS:   prdata = PDATA_W'(max_tasks);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dpfa_ctrl.sv =====
// Sequencing state machine: decode, offset remainder, device scan, drain, commit, finish/return apply.
// Depends on dpfa_pkg.
`default_nettype none

module dpfa_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	output dpfa_pkg::dpfa_cmd_t        cmd,
	input  wire dpfa_pkg::dpfa_stat_t  stat
);
	import dpfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MOD,
		S_SCAN,
		S_DRAIN,
		S_COMMIT,
		S_TAPPLY
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = start;
			S_DECODE: begin
				if (stat.op_reserve && !stat.n_zero) begin
					cmd.reject = 1'b0;
				end else if (stat.tgt_ok) begin
					cmd.tgt_read = 1'b1;
				end else begin
					cmd.reject = 1'b1;
				end
			end
			S_MOD:    cmd.mod_step   = 1'b1;
			S_SCAN:   cmd.scan_issue = 1'b1;
			S_DRAIN:  ;
			S_COMMIT: cmd.commit     = 1'b1;
			S_TAPPLY: cmd.apply      = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
						busy_q  <= 1'b1;
					end
				end
				S_DECODE: begin
					if (stat.op_reserve && !stat.n_zero) begin
						state_q <= S_MOD;
					end else if (stat.tgt_ok) begin
						state_q <= S_TAPPLY;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_MOD: begin
					if (stat.mod_last) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_COMMIT;
				S_COMMIT, S_TAPPLY: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dpfa_dp.sv =====
// Datapath: operand capture, offset remainder unit, device scan with fit
// selection, per-device state RAM with valid bits, result register.
// Depends on dpfa_pkg and dpfa_ram.
`default_nettype none

module dpfa_dp #(
	parameter int MAX_DEVICES = dpfa_pkg::DEF_MAX_DEVICES,
	parameter int MEM_BITS    = dpfa_pkg::DEF_MEM_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire dpfa_pkg::dpfa_cmd_t       cmd,
	output dpfa_pkg::dpfa_stat_t           stat,
	input  wire  [dpfa_pkg::MODE_W-1:0]    fit_mode,
	input  wire  [dpfa_pkg::NDEV_W-1:0]    num_devices,
	input  wire  [dpfa_pkg::SLOT_W-1:0]    max_tasks,
	input  wire  [dpfa_pkg::OPC_W-1:0]     opcode,
	input  wire  [dpfa_pkg::MASK_W-1:0]    device_mask,
	input  wire  [dpfa_pkg::REQ_W-1:0]     request_bytes,
	input  wire  [dpfa_pkg::OFFSET_W-1:0]  start_offset,
	input  wire  [dpfa_pkg::DEVOUT_W-1:0]  target_device,
	output logic                           done,
	output logic                           granted,
	output logic [dpfa_pkg::DEVOUT_W-1:0]  chosen_device,
	output logic [dpfa_pkg::REQ_W-1:0]     remaining_bytes
);
	import dpfa_pkg::*;

	localparam int DEV_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int NW     = $clog2(MAX_DEVICES + 1);
	localparam int CW     = (MEM_BITS > REQ_W) ? MEM_BITS : REQ_W;
	localparam int ENT_W  = MEM_BITS + SLOT_W;
	localparam int STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
	localparam logic [MEM_BITS-1:0] MEM_ONES = '1;

	// captured operands
	logic [OPC_W-1:0]    op_q;
	logic [MASK_W-1:0]   mask_q;
	logic [REQ_W-1:0]    req_q;
	logic [OFFSET_W-1:0] start_q;
	logic [DEVOUT_W-1:0] tgt_q;
	logic [NW-1:0]       n_q;
	logic [OFFSET_W-1:0] rr_q;

	// remainder unit and scan
	logic [NW-1:0]       rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [DEV_W-1:0]    d_q;
	logic [NW-1:0]       cnt_q;
	logic                pv_s1;
	logic [DEV_W-1:0]    dev_s1;
	logic                vld_s1;
	logic                sel_vld_q;
	logic [DEV_W-1:0]    sel_dev_q;
	logic [MEM_BITS-1:0] sel_free_q;
	logic [SLOT_W-1:0]   sel_busy_q;
	logic [MAX_DEVICES-1:0] vld_q;

	// result
	logic                done_q;
	logic                granted_q;
	logic [DEVOUT_W-1:0] chosen_q;
	logic [REQ_W-1:0]    remaining_q;

	logic [7:0]          nd_ext;
	logic [NW-1:0]       n_in;
	logic [7:0]          tgt_ext;
	logic [DEV_W-1:0]    tgt_addr;
	logic [NW-1:0]       rem_nx;
	logic [NW:0]         rem_t;
	logic [NW-1:0]       d_inc;
	logic [DEV_W-1:0]    d_nx;
	logic [DEV_W-1:0]    rd_addr;
	logic [ENT_W-1:0]    rd_data;
	logic [MEM_BITS-1:0] rd_free;
	logic [SLOT_W-1:0]   rd_busy;
	logic [DEV_W+2:0]    dev_ext;
	logic                in_mask;
	logic                elig;
	logic                better;
	logic                take;
	logic                wr_en;
	logic [DEV_W-1:0]    wr_addr;
	logic [ENT_W-1:0]    wr_data;
	logic                res_grant;
	logic [DEV_W-1:0]    res_dev;
	logic [MEM_BITS-1:0] res_free;
	logic [MEM_BITS-1:0] rsv_free;
	logic [SLOT_W-1:0]   slot_inc;
	logic [SLOT_W-1:0]   slot_dec;
	logic [CW:0]         ret_sum;
	logic [MEM_BITS-1:0] ret_free;

	assign nd_ext   = 8'(num_devices);
	assign n_in     = (nd_ext > 8'(MAX_DEVICES)) ? NW'(MAX_DEVICES) : NW'(nd_ext);
	assign tgt_ext  = 8'(tgt_q);
	assign tgt_addr = tgt_ext[DEV_W-1:0];

	assign stat.op_reserve = (op_q == OP_RESERVE);
	assign stat.tgt_ok     = ((op_q == OP_FINISH) || (op_q == OP_RETURN)) &&
		(tgt_ext < 8'(n_q));
	assign stat.n_zero     = (n_q == '0);
	assign stat.mod_last   = (step_q == STEP_W'(MOD_STEPS - 1));
	assign stat.scan_last  = (cnt_q == n_q - 1'b1);

	// MOD_DIGIT restoring steps on the narrow remainder
	always_comb begin
		rem_nx = rem_q;
		rem_t  = '0;
		for (int j = 0; j < MOD_DIGIT; j++) begin
			rem_t = {rem_nx, start_q[OFFSET_W-1-j]};
			if (rem_t >= {1'b0, n_q}) begin
				rem_t = rem_t - {1'b0, n_q};
			end
			rem_nx = rem_t[NW-1:0];
		end
	end

	assign d_inc = NW'(d_q) + 1'b1;
	assign d_nx  = (d_inc == n_q) ? '0 : d_inc[DEV_W-1:0];

	assign rd_addr = cmd.tgt_read ? tgt_addr : d_q;

	dpfa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_DEVICES)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_free = vld_s1 ? rd_data[MEM_BITS-1:0] : '0;
	assign rd_busy = vld_s1 ? rd_data[ENT_W-1:MEM_BITS] : '0;

	assign dev_ext = {3'b000, dev_s1};
	assign in_mask = (dev_ext[DEV_W+2:3] == '0) && mask_q[dev_ext[2:0]];
	assign elig    = pv_s1 && in_mask && (rd_busy < max_tasks) &&
		(CW'(rd_free) >= CW'(req_q));

	always_comb begin
		case (fit_mode)
			FIT_BEST:  better = (rd_free <= sel_free_q);
			FIT_WORST: better = (rd_free >= sel_free_q);
			default:   better = 1'b0;
		endcase
	end

	assign take = elig && (!sel_vld_q || better);

	assign rsv_free = MEM_BITS'(CW'(sel_free_q) - CW'(req_q));
	assign slot_inc = sel_busy_q + 1'b1;
	assign slot_dec = rd_busy - 1'b1;
	assign ret_sum  = (CW + 1)'(rd_free) + (CW + 1)'(req_q);
	assign ret_free = (ret_sum > (CW + 1)'(MEM_ONES)) ? MEM_ONES : ret_sum[MEM_BITS-1:0];

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = sel_dev_q;
		wr_data   = {slot_inc, rsv_free};
		res_grant = 1'b0;
		res_dev   = '0;
		res_free  = '0;
		if (cmd.commit && sel_vld_q) begin
			wr_en     = 1'b1;
			res_grant = 1'b1;
			res_dev   = sel_dev_q;
			res_free  = rsv_free;
		end else if (cmd.apply) begin
			wr_addr = dev_s1;
			if (op_q == OP_FINISH) begin
				wr_data = {slot_dec, rd_free};
				if (rd_busy != '0) begin
					wr_en     = 1'b1;
					res_grant = 1'b1;
					res_dev   = dev_s1;
					res_free  = rd_free;
				end
			end else begin
				wr_data   = {rd_busy, ret_free};
				wr_en     = 1'b1;
				res_grant = 1'b1;
				res_dev   = dev_s1;
				res_free  = ret_free;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q      <= '0;
			step_q    <= '0;
			cnt_q     <= '0;
			pv_s1     <= 1'b0;
			sel_vld_q <= 1'b0;
			vld_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			pv_s1  <= cmd.scan_issue;
			done_q <= cmd.commit | cmd.apply | cmd.reject;
			if (cmd.load && (opcode == OP_RESERVE) && (fit_mode == FIT_RR)) begin
				rr_q <= rr_q + 1'b1;
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.mod_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.mod_step && stat.mod_last) begin
				cnt_q     <= '0;
				sel_vld_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					sel_vld_q <= 1'b1;
				end
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			mask_q  <= device_mask;
			req_q   <= request_bytes;
			tgt_q   <= target_device;
			n_q     <= n_in;
			start_q <= ((opcode == OP_RESERVE) && (fit_mode == FIT_RR)) ? rr_q : start_offset;
			rem_q   <= '0;
		end else if (cmd.mod_step) begin
			start_q <= start_q << MOD_DIGIT;
			rem_q   <= rem_nx;
		end
		if (cmd.mod_step && stat.mod_last) begin
			d_q <= rem_nx[DEV_W-1:0];
		end else if (cmd.scan_issue) begin
			d_q <= d_nx;
		end
		dev_s1 <= rd_addr;
		vld_s1 <= vld_q[rd_addr];
		if (take) begin
			sel_dev_q  <= dev_s1;
			sel_free_q <= rd_free;
			sel_busy_q <= rd_busy;
		end
		if (cmd.commit | cmd.apply | cmd.reject) begin
			granted_q   <= res_grant;
			chosen_q    <= DEVOUT_W'(res_dev);
			remaining_q <= REQ_W'(res_free);
		end
	end

	assign done            = done_q;
	assign granted         = granted_q;
	assign chosen_device   = chosen_q;
	assign remaining_bytes = remaining_q;

endmodule

`default_nettype wire

// ===== rtl/dpfa_checker.sv =====
// Port-level checks on the allocator's command handshake and result strobe,
// bound to the top level. Depends on dpfa_pkg.
`default_nettype none

module dpfa_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire                           granted,
	input wire [dpfa_pkg::DEVOUT_W-1:0]  chosen_device,
	input wire [dpfa_pkg::REQ_W-1:0]     remaining_bytes
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted without busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> (chosen_device == '0) && (remaining_bytes == '0))
		else $error("refused result carries data");

endmodule

bind device_placement_fit_allocator_core dpfa_checker u_dpfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.granted        (granted),
	.chosen_device  (chosen_device),
	.remaining_bytes(remaining_bytes)
);

`default_nettype wire

// ===== tb/device_placement_fit_allocator_core_test.sv =====
// Testbench for device_placement_fit_allocator_core: directed and random operations
// across several register settings, checked against an in-bench placement predictor.
// Depends on dpfa_pkg and the allocator RTL.

module device_placement_fit_allocator_core_test;
	import dpfa_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [REQ_W-1:0] MEM_FULL  = {REQ_W{1'b1}};

	typedef struct packed {
		logic [OPC_W-1:0]    opcode;
		logic [MASK_W-1:0]   mask;
		logic [REQ_W-1:0]    bytes;
		logic [OFFSET_W-1:0] offset;
		logic [DEVOUT_W-1:0] target;
	} alloc_op_t;

	typedef struct packed {
		logic                granted;
		logic [DEVOUT_W-1:0] dev;
		logic [REQ_W-1:0]    left;
	} alloc_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	alloc_op_t drv_op = '0;
	logic done;
	alloc_res_t got;

	device_placement_fit_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.opcode(drv_op.opcode),
		.device_mask(drv_op.mask),
		.request_bytes(drv_op.bytes),
		.start_offset(drv_op.offset),
		.target_device(drv_op.target),
		.done(done),
		.granted(got.granted),
		.chosen_device(got.dev),
		.remaining_bytes(got.left)
	);

	// predictor state and register copies
	logic [REQ_W-1:0]  mem_free [8];
	logic [SLOT_W-1:0] slots [8];
	logic [31:0]       rr_next;
	logic [MODE_W-1:0] mode_cfg;
	logic [NDEV_W-1:0] ndev_cfg;
	logic [SLOT_W-1:0] slot_cap;

	alloc_op_t  op_backlog [$];
	alloc_res_t expected_grants [$];
	int n_queued = 0;
	int n_results = 0;
	int n_fail = 0;
	int n_placed = 0;
	int n_refused = 0;
	int burst_left = 0;
	int gap_left = 0;

	initial forever #5 clk = ~clk;

	function automatic int devices_active();
		return (ndev_cfg > 8) ? 8 : int'(ndev_cfg);
	endfunction

	function automatic alloc_res_t place_and_account(alloc_op_t op);
		alloc_res_t r;
		int n, base, d, sel, i;
		logic [31:0] vstart;
		logic [REQ_W-1:0] left, sel_left;
		logic [REQ_W:0] sum;
		r = '0;
		n = devices_active();
		sel = -1;
		sel_left = '0;
		case (op.opcode)
			OP_RESERVE: begin
				vstart = op.offset;
				if (mode_cfg == FIT_RR) begin
					vstart = rr_next;
					rr_next = rr_next + 32'd1;
				end
				if (n > 0) begin
					base = int'(vstart % n);
					for (i = 0; i < n; i++) begin
						d = (base + i) % n;
						if (op.mask[d] && slots[d] < slot_cap && mem_free[d] >= op.bytes &&
							!(sel >= 0 && (mode_cfg == FIT_FIRST || mode_cfg == FIT_RR))) begin
							left = mem_free[d] - op.bytes;
							if (sel < 0 || (mode_cfg == FIT_BEST && left <= sel_left) ||
								(mode_cfg == FIT_WORST && left >= sel_left)) begin
								sel = d;
								sel_left = left;
							end
						end
					end
					if (sel >= 0) begin
						slots[sel] = slots[sel] + 1'b1;
						mem_free[sel] = mem_free[sel] - op.bytes;
						r.granted = 1'b1;
						r.dev = sel[DEVOUT_W-1:0];
					end
				end
			end
			OP_FINISH: begin
				if (op.target < n && slots[op.target] != 0) begin
					slots[op.target] = slots[op.target] - 1'b1;
					r.granted = 1'b1;
					r.dev = op.target;
				end
			end
			OP_RETURN: begin
				if (op.target < n) begin
					sum = {1'b0, mem_free[op.target]} + op.bytes;
					mem_free[op.target] = sum[REQ_W] ? MEM_FULL : sum[REQ_W-1:0];
					r.granted = 1'b1;
					r.dev = op.target;
				end
			end
			default: ;
		endcase
		if (r.granted)
			r.left = mem_free[r.dev];
		return r;
	endfunction

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk) begin
		alloc_res_t pred;
		if (arst_n) begin
			if (start && !busy) begin
				pred = place_and_account(drv_op);
				expected_grants.push_back(pred);
				if (drv_op.opcode == OP_RESERVE) begin
					if (pred.granted)
						n_placed++;
					else
						n_refused++;
				end
			end
			if (start && busy) begin
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (op_backlog.size() > 0) begin
				drv_op <= op_backlog.pop_front();
				start <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 4) == 0) begin
						burst_left = $urandom_range(40, 80);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 14);
					end
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		alloc_res_t exp_res;
		if (arst_n && done) begin
			n_results++;
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result granted=%0b dev=%0d left=%0h",
					$time, got.granted, got.dev, got.left);
				n_fail++;
			end else begin
				exp_res = expected_grants.pop_front();
				if (got !== exp_res) begin
					$display("%0t: mismatch expected granted=%0b dev=%0d left=%0h, got granted=%0b dev=%0d left=%0h",
						$time, exp_res.granted, exp_res.dev, exp_res.left,
						got.granted, got.dev, got.left);
					n_fail++;
				end
			end
		end
	end

	task automatic queue_op(logic [OPC_W-1:0] opc, logic [MASK_W-1:0] mask,
		logic [REQ_W-1:0] bytes, logic [OFFSET_W-1:0] offset, logic [DEVOUT_W-1:0] target);
		alloc_op_t op;
		op.opcode = opc;
		op.mask = mask;
		op.bytes = bytes;
		op.offset = offset;
		op.target = target;
		op_backlog.push_back(op);
		n_queued++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FIT_MODE: mode_cfg = val[MODE_W-1:0];
			REG_NUM_DEVICES: ndev_cfg = val[NDEV_W-1:0];
			REG_MAX_TASKS: slot_cap = val[SLOT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (n_results == n_queued);
		repeat (3) @(posedge clk);
	endtask

	task automatic queue_random_op();
		logic [OPC_W-1:0] opc;
		logic [63:0] wide;
		logic [REQ_W-1:0] bytes;
		int k, sz, top;
		k = $urandom_range(0, 99);
		opc = (k < 45) ? OP_RESERVE : (k < 65) ? OP_FINISH : (k < 95) ? OP_RETURN : OP_UNUSED;
		wide = {$urandom, $urandom};
		sz = $urandom_range(0, 19);
		if (opc == OP_RESERVE)
			bytes = (sz == 0) ? '0 : (sz < 13) ? REQ_W'($urandom_range(1, 2000)) :
				(sz < 18) ? REQ_W'($urandom_range(0, 1 << 20)) : wide[REQ_W-1:0];
		else
			bytes = (sz < 17) ? REQ_W'($urandom_range(0, 8000)) :
				(sz < 19) ? REQ_W'($urandom_range(0, 1 << 20)) : wide[REQ_W-1:0];
		top = devices_active() > 0 ? devices_active() - 1 : 0;
		queue_op(opc, ($urandom_range(0, 9) < 7) ? MASK_W'($urandom) : 8'hFF, bytes,
			$urandom, ($urandom_range(0, 4) != 0) ? DEVOUT_W'($urandom_range(0, top)) :
			DEVOUT_W'($urandom_range(0, 7)));
	endtask

	initial begin
		int ndev_tab [12];
		int cap_tab [12];
		int p, j, cnt;
		ndev_tab = '{8, 3, 1, 15, 5, 2, 0, 8, 7, 4, 8, 6};
		cap_tab = '{16, 2, 1, 65535, 0, 3, 16, 65535, 4, 1, 8, 5};
		for (j = 0; j < 8; j++) begin
			mem_free[j] = '0;
			slots[j] = '0;
		end
		rr_next = '0;
		mode_cfg = FIT_FIRST;
		ndev_cfg = RST_NUM_DEVICES;
		slot_cap = RST_MAX_TASKS;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings
		queue_op(OP_UNUSED, 8'hFF, MEM_FULL, 32'hFFFF_FFFF, 3'd7);
		queue_op(OP_RESERVE, 8'hFF, '0, '0, 3'd0);
		queue_op(OP_FINISH, 8'h00, '0, '0, 3'd0);
		queue_op(OP_FINISH, 8'h00, '0, '0, 3'd0);
		queue_op(OP_RETURN, 8'h00, MEM_FULL, '0, 3'd7);
		queue_op(OP_RETURN, 8'h00, 48'd1, '0, 3'd7);
		queue_op(OP_RETURN, 8'h00, 48'd1000, '0, 3'd3);
		queue_op(OP_RETURN, 8'h00, 48'd1000, '0, 3'd5);
		queue_op(OP_RESERVE, 8'hFF, 48'd1, 32'hFFFF_FFFF, 3'd0);
		queue_op(OP_RESERVE, 8'h00, 48'd1, '0, 3'd0);
		queue_op(OP_RESERVE, 8'h28, MEM_FULL, '0, 3'd0);
		drain();
		// best fit tie between two devices
		reg_write(REG_FIT_MODE, FIT_BEST);
		queue_op(OP_RESERVE, 8'hFF, 48'd500, '0, 3'd0);
		drain();
		reg_write(REG_FIT_MODE, FIT_WORST);
		queue_op(OP_RESERVE, 8'h28, '0, 32'd5, 3'd0);
		drain();
		reg_write(REG_MAX_TASKS, 32'd0);
		queue_op(OP_RESERVE, 8'hFF, '0, '0, 3'd0);
		drain();
		// targets beyond the device count
		reg_write(REG_NUM_DEVICES, 32'd4);
		reg_write(REG_MAX_TASKS, 32'd65535);
		queue_op(OP_FINISH, 8'h00, '0, '0, 3'd7);
		queue_op(OP_RETURN, 8'h00, 48'd10, '0, 3'd5);
		queue_op(OP_RETURN, 8'h00, 48'd10, '0, 3'd3);
		drain();
		reg_write(REG_NUM_DEVICES, 32'd0);
		queue_op(OP_RESERVE, 8'hFF, '0, '0, 3'd0);
		queue_op(OP_RETURN, 8'h00, 48'd10, '0, 3'd0);
		drain();
		reg_write(REG_NUM_DEVICES, 32'd15);
		reg_write(REG_FIT_MODE, FIT_RR);
		queue_op(OP_RESERVE, 8'hFF, '0, '0, 3'd0);
		queue_op(OP_RESERVE, 8'hFF, '0, '0, 3'd0);
		queue_op(OP_FINISH, 8'h00, '0, '0, 3'd7);
		drain();

		// random phases
		for (p = 0; p < 12; p++) begin
			reg_write(REG_FIT_MODE, p % 4);
			reg_write(REG_NUM_DEVICES, ndev_tab[p]);
			reg_write(REG_MAX_TASKS, cap_tab[p]);
			cnt = (ndev_tab[p] == 0) ? 25 : 135;
			for (j = 0; j < cnt; j++)
				queue_random_op();
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_grants.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_grants.size());
			n_fail++;
		end
		$display("Covered %0d operations over 12 random register settings plus directed cases;",
			n_queued);
		$display("reservations placed %0d, refused %0d, mismatches %0d",
			n_placed, n_refused, n_fail);
		if (n_fail == 0)
			$display("device_placement_fit_allocator_core_test: PASS");
		else
			$display("device_placement_fit_allocator_core_test: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("device_placement_fit_allocator_core_test: FAIL");
		$finish;
	end

endmodule
